@@ src/cramer_pkg.sv @@
// Shared types, widths and the divider step for the 3x3 Cramer solver.
package cramer_pkg;

  localparam int COEF_W    = 16;  // Q7.8 operand
  localparam int PROD_W    = 32;  // 16x16 product
  localparam int MINOR_W   = 33;  // 2x2 minor
  localparam int DET_W     = 49;  // Q24.24 determinant, signed
  localparam int MAG_W     = 48;  // determinant magnitude
  localparam int THR_W     = 40;
  localparam int SOL_W     = 32;  // Q15.16 result
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = SOL_W - 1;      // quotient bits below the sign
  localparam int PRE_SHIFT = QUO_W - FRAC_W; // numerator bits left for the steps to bring in
  localparam int N_EQ      = 3;
  localparam int N_MINOR   = 6;
  localparam int N_TERM    = 12;
  localparam int N_QUO     = 3;
  localparam int PIPE_LAT  = 8 + QUO_W;      // accept edge to strobe sample edge

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);
  localparam logic [SOL_W-1:0] SOL_MAX   = {1'b0, {(SOL_W-1){1'b1}}};
  localparam logic [SOL_W-1:0] SOL_MIN   = {1'b1, {(SOL_W-1){1'b0}}};

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [MINOR_W-1:0] minor_t;
  typedef logic signed [DET_W-1:0]   det_t;
  typedef logic        [MAG_W-1:0]   mag_t;
  typedef logic        [QUO_W-1:0]   quo_t;
  typedef logic signed [SOL_W-1:0]   sol_t;

  typedef struct packed {
    mag_t rem;
    quo_t w;    // remaining numerator bits above, quotient bits shifted in below
  } div_t;

  // One restoring step: bring in the next numerator bit, subtract if it fits.
  function automatic div_t div_step(input div_t cur, input mag_t den);
    logic [MAG_W:0] trial;
    logic           fits;
    div_t           nxt;
    trial   = {cur.rem, cur.w[QUO_W-1]};
    fits    = trial >= {1'b0, den};
    nxt.rem = fits ? MAG_W'(trial - {1'b0, den}) : MAG_W'(trial);
    nxt.w   = {cur.w[QUO_W-2:0], fits};
    return nxt;
  endfunction

endpackage

@@ src/cramer_3x3_linear_solver.sv @@
// Pipelined Cramer's-rule solver for one 3x3 linear system per item.
//
//  channel   signals                                   direction
//  --------  ----------------------------------------  ---------
//  item in   start, busy, coef_*_eq*, rhs_eq*          in / busy out
//  result    done, solvable, sol_x, sol_y, sol_z       out
//  config    cfg_valid, cfg_ready, cfg_data            in / ready out
//
// One item per cycle; results strobe out on done in the order the items were accepted.
// Depth is set by the divider: one restoring step per stage for 31 quotient bits,
// after seven stages of multiplies, minors, determinant sums and setup.
// busy and cfg_ready follow rst; the pipeline never stalls and the receiver
// cannot hold results off. Reset clears all valid bits and restores the threshold.
module cramer_3x3_linear_solver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cramer_pkg::COEF_W-1:0] coef_x_eq0,
  input  logic signed [cramer_pkg::COEF_W-1:0] coef_x_eq1,
  input  logic signed [cramer_pkg::COEF_W-1:0] coef_x_eq2,
  input  logic signed [cramer_pkg::COEF_W-1:0] coef_y_eq0,
  input  logic signed [cramer_pkg::COEF_W-1:0] coef_y_eq1,
  input  logic signed [cramer_pkg::COEF_W-1:0] coef_y_eq2,
  input  logic signed [cramer_pkg::COEF_W-1:0] coef_z_eq0,
  input  logic signed [cramer_pkg::COEF_W-1:0] coef_z_eq1,
  input  logic signed [cramer_pkg::COEF_W-1:0] coef_z_eq2,
  input  logic signed [cramer_pkg::COEF_W-1:0] rhs_eq0,
  input  logic signed [cramer_pkg::COEF_W-1:0] rhs_eq1,
  input  logic signed [cramer_pkg::COEF_W-1:0] rhs_eq2,
  output logic                                done,
  output logic                                solvable,
  output logic signed [cramer_pkg::SOL_W-1:0]  sol_x,
  output logic signed [cramer_pkg::SOL_W-1:0]  sol_y,
  output logic signed [cramer_pkg::SOL_W-1:0]  sol_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [cramer_pkg::THR_W-1:0]  cfg_data
);

  logic [cramer_pkg::THR_W-1:0] threshold;

  // stage 0: captured operands
  logic                 v0;
  cramer_pkg::coef_t    cx [cramer_pkg::N_EQ];
  cramer_pkg::coef_t    cy [cramer_pkg::N_EQ];
  cramer_pkg::coef_t    cz [cramer_pkg::N_EQ];
  cramer_pkg::coef_t    cr [cramer_pkg::N_EQ];

  // stage 1: minor products, row 0 carried along
  logic                 v1;
  cramer_pkg::prod_t    pa [cramer_pkg::N_MINOR];
  cramer_pkg::prod_t    pb [cramer_pkg::N_MINOR];
  cramer_pkg::coef_t    row1 [4];

  // stage 2: 2x2 minors
  logic                 v2;
  cramer_pkg::minor_t   minor [cramer_pkg::N_MINOR];
  cramer_pkg::coef_t    row2 [4];

  // stage 3: row-0 times minor
  logic                 v3;
  cramer_pkg::det_t     term [cramer_pkg::N_TERM];

  // stage 4: determinants, D first then Dx, Dy, Dz
  logic                 v4;
  cramer_pkg::det_t     det [4];

  // stage 5: magnitudes and signs
  logic                 v5;
  logic                 solv5;
  cramer_pkg::mag_t     dmag5;
  cramer_pkg::mag_t     nmag5 [cramer_pkg::N_QUO];
  logic                 neg5  [cramer_pkg::N_QUO];

  // divider pipe: index 0 is the setup stage
  logic [cramer_pkg::QUO_W:0] dv_valid;
  logic                 dv_solv [cramer_pkg::QUO_W+1];
  cramer_pkg::mag_t     dv_den  [cramer_pkg::QUO_W+1];
  logic                 dv_ovf  [cramer_pkg::QUO_W+1][cramer_pkg::N_QUO];
  logic                 dv_neg  [cramer_pkg::QUO_W+1][cramer_pkg::N_QUO];
  cramer_pkg::div_t     dv_st   [cramer_pkg::QUO_W+1][cramer_pkg::N_QUO];

  cramer_pkg::sol_t     sol_next [cramer_pkg::N_QUO];

  assign busy      = rst;
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= cramer_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      dv_valid <= '0;
      done     <= 1'b0;
    end else begin
      v0       <= start && !busy;
      v1       <= v0;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      v5       <= v4;
      dv_valid <= {dv_valid[cramer_pkg::QUO_W-1:0], v5};
      done     <= dv_valid[cramer_pkg::QUO_W];
    end
  end

  // front end: products, minors, determinants, magnitudes and signs
  always_ff @(posedge clk) begin
    cx[0] <= coef_x_eq0;  cx[1] <= coef_x_eq1;  cx[2] <= coef_x_eq2;
    cy[0] <= coef_y_eq0;  cy[1] <= coef_y_eq1;  cy[2] <= coef_y_eq2;
    cz[0] <= coef_z_eq0;  cz[1] <= coef_z_eq1;  cz[2] <= coef_z_eq2;
    cr[0] <= rhs_eq0;     cr[1] <= rhs_eq1;     cr[2] <= rhs_eq2;

    // minors over rows 1 and 2: yz, xz, xy, rz, ry, xr
    pa[0] <= cramer_pkg::prod_t'(cy[1]) * cramer_pkg::prod_t'(cz[2]);
    pb[0] <= cramer_pkg::prod_t'(cy[2]) * cramer_pkg::prod_t'(cz[1]);
    pa[1] <= cramer_pkg::prod_t'(cx[1]) * cramer_pkg::prod_t'(cz[2]);
    pb[1] <= cramer_pkg::prod_t'(cx[2]) * cramer_pkg::prod_t'(cz[1]);
    pa[2] <= cramer_pkg::prod_t'(cx[1]) * cramer_pkg::prod_t'(cy[2]);
    pb[2] <= cramer_pkg::prod_t'(cx[2]) * cramer_pkg::prod_t'(cy[1]);
    pa[3] <= cramer_pkg::prod_t'(cr[1]) * cramer_pkg::prod_t'(cz[2]);
    pb[3] <= cramer_pkg::prod_t'(cr[2]) * cramer_pkg::prod_t'(cz[1]);
    pa[4] <= cramer_pkg::prod_t'(cr[1]) * cramer_pkg::prod_t'(cy[2]);
    pb[4] <= cramer_pkg::prod_t'(cr[2]) * cramer_pkg::prod_t'(cy[1]);
    pa[5] <= cramer_pkg::prod_t'(cx[1]) * cramer_pkg::prod_t'(cr[2]);
    pb[5] <= cramer_pkg::prod_t'(cx[2]) * cramer_pkg::prod_t'(cr[1]);
    row1[0] <= cx[0];
    row1[1] <= cy[0];
    row1[2] <= cz[0];
    row1[3] <= cr[0];

    for (int m = 0; m < cramer_pkg::N_MINOR; m++) begin
      minor[m] <= cramer_pkg::minor_t'(pa[m]) - cramer_pkg::minor_t'(pb[m]);
    end
    row2 <= row1;

    // row2: x0, y0, z0, r0
    term[0]  <= cramer_pkg::det_t'(row2[0]) * cramer_pkg::det_t'(minor[0]);
    term[1]  <= cramer_pkg::det_t'(row2[1]) * cramer_pkg::det_t'(minor[1]);
    term[2]  <= cramer_pkg::det_t'(row2[2]) * cramer_pkg::det_t'(minor[2]);
    term[3]  <= cramer_pkg::det_t'(row2[3]) * cramer_pkg::det_t'(minor[0]);
    term[4]  <= cramer_pkg::det_t'(row2[1]) * cramer_pkg::det_t'(minor[3]);
    term[5]  <= cramer_pkg::det_t'(row2[2]) * cramer_pkg::det_t'(minor[4]);
    term[6]  <= cramer_pkg::det_t'(row2[0]) * cramer_pkg::det_t'(minor[3]);
    term[7]  <= cramer_pkg::det_t'(row2[3]) * cramer_pkg::det_t'(minor[1]);
    term[8]  <= cramer_pkg::det_t'(row2[2]) * cramer_pkg::det_t'(minor[5]);
    term[9]  <= cramer_pkg::det_t'(row2[0]) * cramer_pkg::det_t'(minor[4]);
    term[10] <= cramer_pkg::det_t'(row2[1]) * cramer_pkg::det_t'(minor[5]);
    term[11] <= cramer_pkg::det_t'(row2[3]) * cramer_pkg::det_t'(minor[2]);

    det[0] <= term[0] - term[1] + term[2];
    det[1] <= term[3] - term[4] + term[5];
    det[2] <= term[6] - term[7] + term[8];
    // the z column uses the ry minor with its sign flipped
    det[3] <= term[11] - term[9] - term[10];

    dmag5 <= det[0][cramer_pkg::DET_W-1] ? cramer_pkg::MAG_W'(-det[0])
                                         : cramer_pkg::MAG_W'(det[0]);
    solv5 <= (det[0] != '0) &&
             ((det[0][cramer_pkg::DET_W-1] ? cramer_pkg::MAG_W'(-det[0])
                                           : cramer_pkg::MAG_W'(det[0])) >=
              cramer_pkg::MAG_W'(threshold));
    for (int q = 0; q < cramer_pkg::N_QUO; q++) begin
      nmag5[q] <= det[q+1][cramer_pkg::DET_W-1] ? cramer_pkg::MAG_W'(-det[q+1])
                                                : cramer_pkg::MAG_W'(det[q+1]);
      neg5[q]  <= (det[q+1] != '0) &&
                  (det[q+1][cramer_pkg::DET_W-1] != det[0][cramer_pkg::DET_W-1]);
    end
  end

  // divider setup and steps
  always_ff @(posedge clk) begin
    dv_solv[0] <= solv5;
    dv_den[0]  <= dmag5;
    for (int q = 0; q < cramer_pkg::N_QUO; q++) begin
      // quotient reaches 2^31 when the high numerator part already covers the divisor
      dv_ovf[0][q]   <= cramer_pkg::MAG_W'(nmag5[q][cramer_pkg::MAG_W-1:cramer_pkg::PRE_SHIFT])
                        >= dmag5;
      dv_neg[0][q]   <= neg5[q];
      dv_st[0][q].rem <=
        (cramer_pkg::MAG_W'(nmag5[q][cramer_pkg::MAG_W-1:cramer_pkg::PRE_SHIFT]) >= dmag5)
          ? '0 : cramer_pkg::MAG_W'(nmag5[q][cramer_pkg::MAG_W-1:cramer_pkg::PRE_SHIFT]);
      dv_st[0][q].w   <= {nmag5[q][cramer_pkg::PRE_SHIFT-1:0], {cramer_pkg::FRAC_W{1'b0}}};
    end
    for (int s = 0; s < cramer_pkg::QUO_W; s++) begin
      dv_solv[s+1] <= dv_solv[s];
      dv_den[s+1]  <= dv_den[s];
      for (int q = 0; q < cramer_pkg::N_QUO; q++) begin
        dv_ovf[s+1][q] <= dv_ovf[s][q];
        dv_neg[s+1][q] <= dv_neg[s][q];
        dv_st[s+1][q]  <= cramer_pkg::div_step(dv_st[s][q], dv_den[s]);
      end
    end
  end

  // sign, saturation, and zero for singular systems
  always_comb begin
    for (int q = 0; q < cramer_pkg::N_QUO; q++) begin
      if (!dv_solv[cramer_pkg::QUO_W]) begin
        sol_next[q] = '0;
      end else if (dv_ovf[cramer_pkg::QUO_W][q]) begin
        sol_next[q] = dv_neg[cramer_pkg::QUO_W][q] ? cramer_pkg::SOL_MIN : cramer_pkg::SOL_MAX;
      end else if (dv_neg[cramer_pkg::QUO_W][q]) begin
        sol_next[q] = -cramer_pkg::sol_t'({1'b0, dv_st[cramer_pkg::QUO_W][q].w});
      end else begin
        sol_next[q] = cramer_pkg::sol_t'({1'b0, dv_st[cramer_pkg::QUO_W][q].w});
      end
    end
  end

  always_ff @(posedge clk) begin
    solvable <= dv_solv[cramer_pkg::QUO_W];
    sol_x    <= sol_next[0];
    sol_y    <= sol_next[1];
    sol_z    <= sol_next[2];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(cramer_pkg::PIPE_LAT) done)
    else $error("item accepted without a result at the fixed latency");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !solvable) |-> (sol_x == '0 && sol_y == '0 && sol_z == '0))
    else $error("singular result carries nonzero solution");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (dv_valid[cramer_pkg::QUO_W] && dv_solv[cramer_pkg::QUO_W]) |->
      (dv_st[cramer_pkg::QUO_W][0].rem < dv_den[cramer_pkg::QUO_W] &&
       dv_st[cramer_pkg::QUO_W][1].rem < dv_den[cramer_pkg::QUO_W] &&
       dv_st[cramer_pkg::QUO_W][2].rem < dv_den[cramer_pkg::QUO_W]))
    else $error("divider remainder not below the divisor");

endmodule

@@ test/tb_cramer_3x3_linear_solver.sv @@
// Self-checking testbench for the 3x3 Cramer solver: random bursts, threshold phases, predictor.
`timescale 1ns / 1ps

module tb_cramer_3x3_linear_solver;

  localparam int COL_X      = 0;
  localparam int COL_Y      = 1;
  localparam int COL_Z      = 2;
  localparam int COL_R      = 3;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_ITEMS = 200;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    cramer_pkg::coef_t m [3][4];  // [equation][x, y, z, rhs]
  } system_t;

  typedef struct {
    logic ok;
    cramer_pkg::sol_t x;
    cramer_pkg::sol_t y;
    cramer_pkg::sol_t z;
  } solution_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  cramer_pkg::coef_t coef_x_eq0 = '0, coef_x_eq1 = '0, coef_x_eq2 = '0;
  cramer_pkg::coef_t coef_y_eq0 = '0, coef_y_eq1 = '0, coef_y_eq2 = '0;
  cramer_pkg::coef_t coef_z_eq0 = '0, coef_z_eq1 = '0, coef_z_eq2 = '0;
  cramer_pkg::coef_t rhs_eq0 = '0, rhs_eq1 = '0, rhs_eq2 = '0;
  logic              done;
  logic              solvable;
  cramer_pkg::sol_t  sol_x, sol_y, sol_z;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [cramer_pkg::THR_W-1:0] cfg_data = '0;

  system_t           pending_q[$];
  solution_t         solution_q[$];
  system_t           cur_sys;
  logic [cramer_pkg::THR_W-1:0] singular_limit = cramer_pkg::THR_RESET;
  logic              loaded = 1'b0;
  logic              hold_for_drain = 1'b0;
  int                burst_left = 0;
  int                gap_left = 0;
  int                errors = 0;
  int                idle_cycles = 0;

  cramer_3x3_linear_solver dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .coef_x_eq0 (coef_x_eq0),
    .coef_x_eq1 (coef_x_eq1),
    .coef_x_eq2 (coef_x_eq2),
    .coef_y_eq0 (coef_y_eq0),
    .coef_y_eq1 (coef_y_eq1),
    .coef_y_eq2 (coef_y_eq2),
    .coef_z_eq0 (coef_z_eq0),
    .coef_z_eq1 (coef_z_eq1),
    .coef_z_eq2 (coef_z_eq2),
    .rhs_eq0    (rhs_eq0),
    .rhs_eq1    (rhs_eq1),
    .rhs_eq2    (rhs_eq2),
    .done       (done),
    .solvable   (solvable),
    .sol_x      (sol_x),
    .sol_y      (sol_y),
    .sol_z      (sol_z),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Determinant of the matrix built from columns p, q, r of the system.
  function automatic longint det_cols(input longint v [3][4], input int p, input int q,
                                      input int r);
    return v[0][p] * (v[1][q] * v[2][r] - v[2][q] * v[1][r])
         - v[0][q] * (v[1][p] * v[2][r] - v[2][p] * v[1][r])
         + v[0][r] * (v[1][p] * v[2][q] - v[2][p] * v[1][q]);
  endfunction

  // Q16 quotient, truncated toward zero, saturated to the Q15.16 range.
  function automatic cramer_pkg::sol_t quotient_q16(input longint num, input longint den);
    logic                neg;
    longint unsigned     n, d, qi, rem, q;
    neg = (num < 0) != (den < 0);
    n   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    qi  = n / d;
    rem = n % d;
    if (qi >= 64'd65536)
      return neg ? cramer_pkg::SOL_MIN : cramer_pkg::SOL_MAX;
    q = (qi << 16) + ((rem << 16) / d);
    if (neg) begin
      if (q >= 64'h8000_0000)
        return cramer_pkg::SOL_MIN;
      return cramer_pkg::sol_t'(-q);
    end
    if (q > 64'h7FFF_FFFF)
      return cramer_pkg::SOL_MAX;
    return cramer_pkg::sol_t'(q);
  endfunction

  function automatic solution_t solve_system(input system_t s,
                                             input logic [cramer_pkg::THR_W-1:0] limit);
    longint          v [3][4];
    longint          d;
    longint unsigned mag;
    solution_t       res;
    for (int k = 0; k < 3; k++)
      for (int c = 0; c < 4; c++)
        v[k][c] = longint'(s.m[k][c]);
    d   = det_cols(v, COL_X, COL_Y, COL_Z);
    mag = (d < 0) ? -d : d;
    res = '{ok: 1'b0, x: '0, y: '0, z: '0};
    if (d == 0 || mag < limit)
      return res;
    res.ok = 1'b1;
    res.x  = quotient_q16(det_cols(v, COL_R, COL_Y, COL_Z), d);
    res.y  = quotient_q16(det_cols(v, COL_X, COL_R, COL_Z), d);
    res.z  = quotient_q16(det_cols(v, COL_X, COL_Y, COL_R), d);
    return res;
  endfunction

  function automatic system_t sys12(input int x0, y0, z0, r0, input int x1, y1, z1, r1,
                                    input int x2, y2, z2, r2);
    system_t s;
    s.m[0][COL_X] = cramer_pkg::coef_t'(x0); s.m[0][COL_Y] = cramer_pkg::coef_t'(y0);
    s.m[0][COL_Z] = cramer_pkg::coef_t'(z0); s.m[0][COL_R] = cramer_pkg::coef_t'(r0);
    s.m[1][COL_X] = cramer_pkg::coef_t'(x1); s.m[1][COL_Y] = cramer_pkg::coef_t'(y1);
    s.m[1][COL_Z] = cramer_pkg::coef_t'(z1); s.m[1][COL_R] = cramer_pkg::coef_t'(r1);
    s.m[2][COL_X] = cramer_pkg::coef_t'(x2); s.m[2][COL_Y] = cramer_pkg::coef_t'(y2);
    s.m[2][COL_Z] = cramer_pkg::coef_t'(z2); s.m[2][COL_R] = cramer_pkg::coef_t'(r2);
    return s;
  endfunction

  function automatic cramer_pkg::coef_t pick(input int lo, input int hi);
    return cramer_pkg::coef_t'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  function automatic cramer_pkg::coef_t pick_extreme();
    case ($urandom_range(0, 6))
      0:       return cramer_pkg::coef_t'(-32768);
      1:       return cramer_pkg::coef_t'(32767);
      2:       return cramer_pkg::coef_t'(0);
      3:       return cramer_pkg::coef_t'(1);
      4:       return cramer_pkg::coef_t'(-1);
      5:       return cramer_pkg::coef_t'(256);
      default: return cramer_pkg::coef_t'(-256);
    endcase
  endfunction

  function automatic system_t random_system();
    system_t s;
    int      i, j, c;
    for (int k = 0; k < 3; k++)
      for (int col = 0; col < 4; col++)
        s.m[k][col] = cramer_pkg::coef_t'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: ;  // full-range operands
      3, 4: begin
        for (int k = 0; k < 3; k++)
          for (int col = 0; col < 3; col++)
            s.m[k][col] = pick(-1024, 1024);
      end
      5, 6: begin
        // third equation nearly the sum of the first two
        for (int k = 0; k < 2; k++)
          for (int col = 0; col < 3; col++)
            s.m[k][col] = pick(-2000, 2000);
        for (int col = 0; col < 3; col++)
          s.m[2][col] = s.m[0][col] + s.m[1][col];
        c = $urandom_range(0, 2);
        s.m[2][c] = s.m[2][c] + pick(-2, 2);
      end
      7: begin
        i = $urandom_range(0, 2);
        j = (i + 1 + $urandom_range(0, 1)) % 3;
        c = $urandom_range(0, 2);
        case ($urandom_range(0, 2))
          0: for (int col = 0; col < 3; col++) s.m[j][col] = s.m[i][col];
          1: for (int k = 0; k < 3; k++) s.m[k][c] = '0;
          default: begin
            for (int col = 0; col < 3; col++) begin
              s.m[i][col] = pick(-16000, 16000);
              s.m[j][col] = cramer_pkg::coef_t'(s.m[i][col] * 2);
            end
          end
        endcase
      end
      8: begin
        // small diagonal, large right-hand sides: drives saturation
        for (int k = 0; k < 3; k++)
          for (int col = 0; col < 3; col++)
            s.m[k][col] = (k == col)
                ? cramer_pkg::coef_t'(pick(1, 64) * ($urandom_range(0, 1) ? 1 : -1))
                : pick(-4, 4);
      end
      default: begin
        for (int k = 0; k < 3; k++)
          for (int col = 0; col < 4; col++)
            s.m[k][col] = pick_extreme();
      end
    endcase
    return s;
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || loaded || start || solution_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_threshold(input logic [cramer_pkg::THR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    singular_limit = value;
  endtask

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++)
      pending_q.push_back(random_system());
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < MAX_PRINTS)
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // Driver: hold an item until accepted, then load the next one unless in a gap or a drain.
  always @(posedge clk) begin
    if (rst) begin
      loaded         = 1'b0;
      hold_for_drain = 1'b0;
      burst_left     = 0;
      gap_left       = 0;
      start         <= 1'b0;
    end else begin
      if (start && !busy) begin
        solution_q.push_back(solve_system(cur_sys, singular_limit));
        loaded = 1'b0;
      end
      if (!loaded) begin
        if (hold_for_drain) begin
          if (solution_q.size() == 0)
            hold_for_drain = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          cur_sys = pending_q.pop_front();
          loaded  = 1'b1;
          coef_x_eq0 <= cur_sys.m[0][COL_X];
          coef_x_eq1 <= cur_sys.m[1][COL_X];
          coef_x_eq2 <= cur_sys.m[2][COL_X];
          coef_y_eq0 <= cur_sys.m[0][COL_Y];
          coef_y_eq1 <= cur_sys.m[1][COL_Y];
          coef_y_eq2 <= cur_sys.m[2][COL_Y];
          coef_z_eq0 <= cur_sys.m[0][COL_Z];
          coef_z_eq1 <= cur_sys.m[1][COL_Z];
          coef_z_eq2 <= cur_sys.m[2][COL_Z];
          rhs_eq0    <= cur_sys.m[0][COL_R];
          rhs_eq1    <= cur_sys.m[1][COL_R];
          rhs_eq2    <= cur_sys.m[2][COL_R];
          if (burst_left == 0)
            burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          // now and then drain the pipeline before the next item
          if ($urandom_range(0, 149) == 0)
            hold_for_drain = 1'b1;
        end
      end
      start <= loaded;
    end
  end

  // Monitor: every strobe must match the oldest expected solution.
  always @(posedge clk) begin
    solution_t want;
    if (!rst && done) begin
      if (solution_q.size() == 0) begin
        report_mismatch("result with no item pending, sol_x", longint'(sol_x), 0);
      end else begin
        want = solution_q.pop_front();
        if (solvable !== want.ok)
          report_mismatch("solvable", longint'(solvable), longint'(want.ok));
        if (sol_x !== want.x)
          report_mismatch("sol_x", longint'(sol_x), longint'(want.x));
        if (sol_y !== want.y)
          report_mismatch("sol_y", longint'(sol_y), longint'(want.y));
        if (sol_z !== want.z)
          report_mismatch("sol_z", longint'(sol_z), longint'(want.z));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("cramer_3x3_linear_solver: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset threshold: zero, identity, extremes, threshold boundary, singular, truncation, saturation
    pending_q.push_back(sys12(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(sys12(256, 0, 0, 32767, 0, 256, 0, -32768, 0, 0, 256, 0));
    pending_q.push_back(sys12(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                              32767, 32767, 32767, 32767));
    pending_q.push_back(sys12(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768, -32768, -32768));
    pending_q.push_back(sys12(32767, 0, 0, -32768, 0, 32767, 0, 32767, 0, 0, 32767, 1));
    pending_q.push_back(sys12(-32768, 0, 0, 32767, 0, -32768, 0, -32768, 0, 0, -32768, -1));
    pending_q.push_back(sys12(1, 0, 0, 1, 0, 1, 0, -1, 0, 0, 17, 17));
    pending_q.push_back(sys12(1, 0, 0, 1, 0, 1, 0, -1, 0, 0, 16, 16));
    pending_q.push_back(sys12(-1, 0, 0, 5, 0, 1, 0, 7, 0, 0, 17, -17));
    pending_q.push_back(sys12(-1, 0, 0, -32768, 0, 16, 0, 32767, 0, 0, 16, -32768));
    pending_q.push_back(sys12(1, 0, 0, -32768, 0, 16, 0, 16, 0, 0, 16, -16));
    pending_q.push_back(sys12(768, 0, 0, 256, 0, 768, 0, -256, 0, 0, 768, 512));
    pending_q.push_back(sys12(512, 256, 256, 1000, 256, 768, 512, -3000, 256, 0, 0, 77));
    pending_q.push_back(sys12(256, 256, 0, 32767, 256, 257, 0, -32768, 0, 0, 256, 1));
    pending_q.push_back(sys12(300, -200, 17, 5, 300, -200, 17, 9, 40, 50, 60, 1));
    pending_q.push_back(sys12(300, -200, 0, 5, 11, 22, 0, 9, 40, 50, 0, 1));
    pending_q.push_back(sys12(-7, 3, 1, -32768, 2, -9, 4, 32767, 5, 6, -8, -1));
    queue_random(PHASE_ITEMS);
    wait_idle();

    // zero threshold: only an exact zero determinant is singular
    write_threshold('0);
    pending_q.push_back(sys12(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(sys12(5, 6, 7, 1, 5, 6, 7, 2, 1, 1, 1, 3));
    pending_q.push_back(sys12(1, 0, 0, -32768, 0, 1, 0, 32767, 0, 0, 1, 5));
    pending_q.push_back(sys12(-1, 0, 0, -32768, 0, 1, 0, 32767, 0, 0, 1, -5));
    pending_q.push_back(sys12(1, 1, 0, 32767, 1, 2, 0, -32768, 0, 0, 1, 0));
    queue_random(PHASE_ITEMS);
    wait_idle();

    write_threshold({cramer_pkg::THR_W{1'b1}});
    queue_random(PHASE_ITEMS);
    wait_idle();

    write_threshold(cramer_pkg::THR_W'(1) << 24);
    queue_random(PHASE_ITEMS);
    wait_idle();

    write_threshold(cramer_pkg::THR_W'($urandom_range(0, 32'h3FFF_FFFF)));
    queue_random(PHASE_ITEMS);
    wait_idle();

    write_threshold(cramer_pkg::THR_RESET);
    queue_random(PHASE_ITEMS);
    wait_idle();

    repeat (cramer_pkg::PIPE_LAT + 10) @(posedge clk);
    if (errors == 0)
      $display("cramer_3x3_linear_solver: match");
    else
      $display("cramer_3x3_linear_solver: mismatch");
    $finish;
  end

endmodule
